@@ rtl/gsrp_pkg.sv @@
// Package for the serial gamepad poller: phase codes, result layout and fixed constants.
// No dependencies; used by gamepad_shift_register_poller_core.
`default_nettype none

package gsrp_pkg;

   localparam int unsigned THRESHOLD_WIDTH = 16;
   localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = 16'd150;
   localparam int unsigned INDEX_WIDTH = 3;
   localparam int unsigned REQ_DATA_WIDTH = 8;
   localparam int unsigned RSP_DATA_WIDTH = 8;

   // Latch is high only in LATCH_LO, clock only in CLOCK_LO (after the line goes up).
   typedef enum logic [2:0] {
      PHASE_WAIT     = 3'd0,
      PHASE_LATCH_HI = 3'd1,
      PHASE_LATCH_LO = 3'd2,
      PHASE_SAMPLE   = 3'd3,
      PHASE_CLOCK_HI = 3'd4,
      PHASE_CLOCK_LO = 3'd5
   } phase_type;

   typedef struct packed {
      logic                   frame_done;
      logic                   button_pressed;
      logic [INDEX_WIDTH-1:0] button_index;
      logic                   sample_valid;
      logic                   clock_level;
      logic                   latch_level;
      logic                   pad_echo;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/gamepad_shift_register_poller_core.sv @@
// Top level of the serial gamepad poller: per-pad phase machines and a two-entry result buffer.
// Depends on gsrp_pkg.
//
//  Channel | Direction | Handshake             | Contents
//  req     | in        | req_tvalid/req_tready | tdata: tick, data pin; tuser: pad
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: lines, sample; tuser: pad; tlast: frame end
//  csr     | in        | csr_wr_en             | csr_wr_data: wait threshold
//
// Each request is decoded and applied to its pad's state in the cycle it is accepted, so one
// request per cycle is taken while req_tready is high; its response is registered for output.
// Responses sit in an output register backed by one skid entry; req_tready drops only while
// the skid entry holds a response. Synchronous reset puts both pads in the wait phase and
// loads the threshold with 150.
`default_nettype none

module gamepad_shift_register_poller_core #(
   parameter int unsigned BUTTON_COUNT = 8,
   parameter int unsigned PAD_COUNT    = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [0] tick_pending, [1] data_level, [7:2] zero
   input  wire logic [gsrp_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // [0] pad_select
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [0] latch_level, [1] clock_level, [2] sample_valid, [5:3] button_index,
   // [6] button_pressed, [7] zero
   output logic [gsrp_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata,
   // [0] pad_echo
   output logic                                      rsp_tuser,
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_wr_en,
   input  wire logic [gsrp_pkg::THRESHOLD_WIDTH-1:0] csr_wr_data
);
   import gsrp_pkg::*;

   // Only two pads can be addressed through a one-bit select.
   localparam int unsigned PAD_SLOTS = (PAD_COUNT < 2) ? PAD_COUNT : 2;
   localparam int unsigned POS_WIDTH = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
   localparam logic [POS_WIDTH:0] LAST_COUNT = (POS_WIDTH + 1)'(BUTTON_COUNT);

   logic [THRESHOLD_WIDTH-1:0] threshold_ff;
   phase_type                  phase_ff [PAD_SLOTS];
   logic [THRESHOLD_WIDTH-1:0] wait_count_ff [PAD_SLOTS];
   logic [POS_WIDTH-1:0]       bit_pos_ff [PAD_SLOTS];

   phase_type                  phase_cur;
   logic [THRESHOLD_WIDTH-1:0] wait_count_cur;
   logic [POS_WIDTH-1:0]       bit_pos_cur;
   phase_type                  phase_in;
   logic [THRESHOLD_WIDTH-1:0] wait_count_in;
   logic [POS_WIDTH-1:0]       bit_pos_in;
   logic [THRESHOLD_WIDTH-1:0] count_inc;
   logic [POS_WIDTH:0]         pos_inc;

   logic       tick;
   logic       pad_ok;
   logic       accept;
   logic       sampled;
   logic       last_button;
   result_type result;

   result_type out_ff;
   result_type skid_ff;
   logic       out_valid_ff;
   logic       skid_valid_ff;
   logic       pop;

   assign tick   = req_tdata[0];
   assign pad_ok = (PAD_COUNT > 1) || (req_tuser == 1'b0);
   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   always_comb begin
      phase_cur      = PHASE_WAIT;
      wait_count_cur = '0;
      bit_pos_cur    = '0;
      for (int p = 0; p < PAD_SLOTS; p++) begin
         if (req_tuser == 1'(p)) begin
            phase_cur      = phase_ff[p];
            wait_count_cur = wait_count_ff[p];
            bit_pos_cur    = bit_pos_ff[p];
         end
      end
   end

   assign count_inc   = wait_count_cur + 1'b1;
   assign pos_inc     = {1'b0, bit_pos_cur} + 1'b1;
   assign last_button = (pos_inc >= LAST_COUNT);

   // Next state of the addressed pad.
   always_comb begin
      phase_in      = phase_cur;
      wait_count_in = wait_count_cur;
      bit_pos_in    = bit_pos_cur;
      if (tick) begin
         case (phase_cur)
            PHASE_WAIT: begin
               if (count_inc > threshold_ff) begin
                  wait_count_in = '0;
                  phase_in      = PHASE_LATCH_HI;
               end else begin
                  wait_count_in = count_inc;
               end
            end
            PHASE_LATCH_HI: phase_in = PHASE_LATCH_LO;
            PHASE_LATCH_LO: phase_in = PHASE_SAMPLE;
            PHASE_SAMPLE: begin
               if (last_button) begin
                  bit_pos_in = '0;
                  phase_in   = PHASE_WAIT;
               end else begin
                  bit_pos_in = pos_inc[POS_WIDTH-1:0];
                  phase_in   = PHASE_CLOCK_HI;
               end
            end
            PHASE_CLOCK_HI: phase_in = PHASE_CLOCK_LO;
            PHASE_CLOCK_LO: phase_in = PHASE_SAMPLE;
            default:        phase_in = PHASE_WAIT;
         endcase
      end
   end

   // Response fields; an unused pad answers with everything but its number cleared.
   always_comb begin
      sampled = tick && (phase_cur == PHASE_SAMPLE);
      result  = '0;
      result.pad_echo = req_tuser;
      if (pad_ok) begin
         result.latch_level    = (phase_in == PHASE_LATCH_LO);
         result.clock_level    = (phase_in == PHASE_CLOCK_LO);
         result.sample_valid   = sampled;
         result.button_pressed = sampled && !req_tdata[1];
         result.frame_done     = sampled && last_button;
         if (sampled) begin
            result.button_index = INDEX_WIDTH'({{INDEX_WIDTH{1'b0}}, bit_pos_cur});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < PAD_SLOTS; p++) begin
         if (reset) begin
            phase_ff[p]      <= PHASE_WAIT;
            wait_count_ff[p] <= '0;
            bit_pos_ff[p]    <= '0;
         end else if (accept && tick && pad_ok && (req_tuser == 1'(p))) begin
            phase_ff[p]      <= phase_in;
            wait_count_ff[p] <= wait_count_in;
            bit_pos_ff[p]    <= bit_pos_in;
         end
      end
   end

   // Output register with one skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.pad_echo;
   assign rsp_tlast  = out_ff.frame_done;
   assign rsp_tdata  = {1'b0, out_ff.button_pressed, out_ff.button_index,
                        out_ff.sample_valid, out_ff.clock_level, out_ff.latch_level};

endmodule

`default_nettype wire
